>>> hw/rtl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    localparam int unsigned SYM_W  = 7;
    localparam int unsigned CODE_W = 31;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ACC_W  = 7;
    localparam int unsigned CNT_W  = 3;
    // pending bits plus the longest code, rounded up to whole bytes
    localparam int unsigned BUF_W  = 40;
    localparam int unsigned TOT_W  = 6;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
    } hcbp_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/hcbp_code_table.sv
// code table memory with per-entry valid bits and registered read
`timescale 1ns / 1ps
`default_nettype none

module hcbp_code_table
    import hcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 128,
    localparam int IDX_W = $clog2(SYMBOL_COUNT)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire logic [CODE_W-1:0] wr_code,
    input  wire logic [LEN_W-1:0]  wr_len,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic      [CODE_W-1:0] rd_code,
    output logic      [LEN_W-1:0]  rd_len
);

    logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic [CODE_W+LEN_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_code, wr_len};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    // an entry never loaded reads as length zero
    assign rd_code = rd_valid_reg ? rd_data_reg[CODE_W+LEN_W-1:LEN_W] : '0;
    assign rd_len  = rd_valid_reg ? rd_data_reg[LEN_W-1:0] : '0;

endmodule

`default_nettype wire

>>> hw/rtl/hcbp_packer.sv
// bit accumulator, byte packing and output byte buffer
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer
    import hcbp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire hcbp_item_t        item,
    input  wire logic [CODE_W-1:0] entry_code,
    input  wire logic [LEN_W-1:0]  entry_len,
    output logic                   item_take,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last_of_run,
    output logic                   stream_end,
    output logic                   out_valid,
    input  wire logic              out_ready
);

    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]        pend_reg, pend_next;
    logic [BUF_W-1:0]        buf_reg, buf_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    fin_reg, fin_next;

    logic                    appends;
    logic                    is_finish;
    logic [LEN_W-1:0]        len_eff;
    logic [CODE_W-1:0]       code_eff;
    logic [CODE_W+ACC_W-1:0] combined;
    logic [TOT_W-1:0]        total;
    logic [BUF_W-1:0]        aligned;
    logic [CNT_W-1:0]        full_bytes;
    logic                    pad;
    logic                    pop;

    assign pop       = out_valid && out_ready;
    assign item_take = item_valid && ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready));

    always_comb
    begin
        is_finish = (item.op == OP_FINISH);
        appends   = ((item.op == OP_ENCODE) || is_finish) && item.hit;
        len_eff   = appends ? entry_len : '0;
        // a request that appends nothing must leave the pending bits alone
        code_eff  = appends ? entry_code : '0;
        combined  = ({{CODE_W{1'b0}}, acc_reg} << len_eff) | {{ACC_W{1'b0}}, code_eff};
        total     = TOT_W'(pend_reg) + TOT_W'(len_eff);
        // left-align the valid bits so the first byte sits at the top
        aligned    = {{(BUF_W-CODE_W-ACC_W){1'b0}}, combined} << (TOT_W'(BUF_W) - total);
        full_bytes = total[TOT_W-1:3];
        pad        = is_finish && (total[2:0] != '0);

        if (is_finish)
        begin
            acc_next  = '0;
            pend_next = '0;
        end
        else
        begin
            acc_next  = combined[ACC_W-1:0] & ~({ACC_W{1'b1}} << total[2:0]);
            pend_next = total[2:0];
        end

        buf_next = buf_reg;
        cnt_next = cnt_reg;
        fin_next = fin_reg;
        if (item_take)
        begin
            buf_next = aligned;
            cnt_next = full_bytes + CNT_W'(pad);
            fin_next = is_finish;
        end
        else if (pop)
        begin
            buf_next = buf_reg << BYTE_W;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
            end
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign out_valid   = (cnt_reg != '0);
    assign out_byte    = buf_reg[BUF_W-1 -: BYTE_W];
    assign last_of_run = (cnt_reg == CNT_W'(1));
    assign stream_end  = (cnt_reg == CNT_W'(1)) && fin_reg;

endmodule

`default_nettype wire

>>> hw/rtl/huffman_code_bit_packer_top.sv
// huffman code bit packer: top level with input stage and table lookup
`timescale 1ns / 1ps
`default_nettype none

// Table-driven Huffman bit packer. A request with operation load writes one
// code table entry; encode appends the symbol's code MSB-first to the bit
// accumulator and emits each completed byte; finish appends the code of
// symbol 0, pads any partial byte with zeros and flags the final byte with
// stream_end. last_of_run marks the final byte caused by each request. A
// request passes through a table read stage and a packing stage into a
// byte buffer that drains one byte per cycle while out_ready is high; a
// request's bytes hold the packer until the last of them leaves, up to 4 bytes
// for encode and 5 for finish, as the output port is a single byte wide.
// A new request is taken while the previous one's bytes are still
// draining. Each request's table entry is registered, then its bytes in
// the byte buffer. The table is empty after reset with no clearing pass.
module huffman_code_bit_packer_top
    import hcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT    = 128,
    parameter int MAX_CODE_LENGTH = 31
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [CODE_W-1:0] code_bits,
    input  wire logic [LEN_W-1:0]  code_length,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last_of_run,
    output logic                   stream_end
);

    localparam int IDX_W = $clog2(SYMBOL_COUNT);
    localparam int EXT_W = 9;

    logic                    accept;
    logic [EXT_W-1:0]        sym_ext;
    logic                    in_range;
    logic [LEN_W-1:0]        len_clamped;
    logic [CODE_W-1:0]       code_masked;
    logic                    wr_en;
    logic [IDX_W-1:0]        rd_idx;
    logic [CODE_W-1:0]       entry_code;
    logic [LEN_W-1:0]        entry_len;
    logic                    item_take;

    logic                    s1_valid_reg;
    hcbp_item_t              s1_item_reg;

    assign accept   = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || item_take;

    always_comb
    begin
        sym_ext     = EXT_W'(symbol);
        in_range    = sym_ext < EXT_W'(SYMBOL_COUNT);
        len_clamped = (code_length > LEN_W'(MAX_CODE_LENGTH)) ?
                      LEN_W'(MAX_CODE_LENGTH) : code_length;
        code_masked = code_bits & ~({CODE_W{1'b1}} << len_clamped);
        wr_en       = accept && (operation == OP_LOAD) && in_range;
        // finish always reads the end marker entry
        rd_idx      = (operation == OP_FINISH) ? '0 : sym_ext[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_item_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg    <= 1'b1;
                s1_item_reg.op  <= operation;
                s1_item_reg.hit <= in_range || (operation == OP_FINISH);
            end
            else if (item_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    hcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_idx   (sym_ext[IDX_W-1:0]),
        .wr_code  (code_masked),
        .wr_len   (len_clamped),
        .rd_en    (accept),
        .rd_idx   (rd_idx),
        .rd_code  (entry_code),
        .rd_len   (entry_len)
    );

    hcbp_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s1_valid_reg),
        .item        (s1_item_reg),
        .entry_code  (entry_code),
        .entry_len   (entry_len),
        .item_take   (item_take),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

`default_nettype wire

>>> sim/tb_huffman_code_bit_packer_top.sv
// testbench for the huffman code bit packer top level
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_top;
    import hcbp_pkg::*;

    localparam int unsigned TABLE_DEPTH    = 128;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_SHOWN      = 60;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              stream_done;
    } packed_byte_t;

    // keeps a model of the code table and bit accumulator, and the bytes still owed
    class packer_scoreboard;
        logic [CODE_W-1:0] code_of [TABLE_DEPTH];
        logic [LEN_W-1:0]  length_of [TABLE_DEPTH];
        logic [ACC_W-1:0]  pend_bits;
        int unsigned       pend_count;
        packed_byte_t      run_bytes[$];
        packed_byte_t      expected_bytes[$];
        int unsigned       errors;
        int unsigned       bytes_checked;

        function new();
            foreach (code_of[i])
            begin
                code_of[i]   = '0;
                length_of[i] = '0;
            end
            pend_bits     = '0;
            pend_count    = 0;
            errors        = 0;
            bytes_checked = 0;
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_SHOWN)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // shift a code into the accumulator, peeling off every full byte
        function void append_code(input logic [CODE_W-1:0] code, input int unsigned len);
            logic [63:0]  acc;
            logic [63:0]  rest;
            int unsigned  total;
            packed_byte_t item;
            total = pend_count + len;
            acc = ({57'd0, pend_bits} << len) | ({33'd0, code} & ((64'd1 << len) - 64'd1));
            while (total >= BYTE_W)
            begin
                item.data        = 8'(acc >> (total - BYTE_W));
                item.last        = 1'b0;
                item.stream_done = 1'b0;
                run_bytes.push_back(item);
                total -= BYTE_W;
            end
            rest       = acc & ((64'd1 << total) - 64'd1);
            pend_bits  = rest[ACC_W-1:0];
            pend_count = total;
        endfunction

        function void predict_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
            packed_byte_t item;
            int           n;
            run_bytes.delete();
            case (op)
                OP_LOAD:
                begin
                    length_of[sym] = len;
                    code_of[sym]   = bits & CODE_W'((64'd1 << len) - 64'd1);
                end
                OP_ENCODE:
                    append_code(code_of[sym], length_of[sym]);
                OP_FINISH:
                begin
                    append_code(code_of[0], length_of[0]);
                    if (pend_count != 0)
                    begin
                        // zero pad the partial byte
                        item.data        = 8'({1'b0, pend_bits} << (BYTE_W - pend_count));
                        item.last        = 1'b0;
                        item.stream_done = 1'b0;
                        run_bytes.push_back(item);
                        pend_bits  = '0;
                        pend_count = 0;
                    end
                end
                default:
                    ;
            endcase
            n = run_bytes.size();
            if (n > 0)
            begin
                run_bytes[n-1].last = 1'b1;
                if (op == OP_FINISH)
                    run_bytes[n-1].stream_done = 1'b1;
            end
            foreach (run_bytes[i])
                expected_bytes.push_back(run_bytes[i]);
        endfunction

        task check_byte(input logic [BYTE_W-1:0] data, input logic last, input logic done);
            packed_byte_t want;
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("byte %02h with nothing expected", data));
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (data !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
                if (last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                              last, want.last, want.data));
                if (done !== want.stream_done)
                    report_mismatch($sformatf("stream_end %b, expected %b on byte %02h",
                                              done, want.stream_done, want.data));
            end
        endtask

        task check_leftover();
            if (expected_bytes.size() != 0)
                report_mismatch($sformatf("%0d expected bytes never came out",
                                          expected_bytes.size()));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_end;

    packer_scoreboard board = new();

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned stall_cycles;
    int unsigned loads_taken;
    int unsigned encodes_taken;
    int unsigned finishes_taken;
    int unsigned others_taken;

    huffman_code_bit_packer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stream_end  (stream_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // accepted requests feed the model, accepted bytes are checked against it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_byte(out_byte, last_of_run, stream_end);
            if (in_valid && in_ready)
            begin
                board.predict_request(operation, symbol, code_bits, code_length);
                case (operation)
                    OP_LOAD:   loads_taken++;
                    OP_ENCODE: encodes_taken++;
                    OP_FINISH: finishes_taken++;
                    default:   others_taken++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // output side backpressure, with an optional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                      input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        symbol      <= sym;
        code_bits   <= bits;
        code_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        // let the monitor record the request taken at the last edge
        @(posedge clk);
        while (board.expected_bytes.size() > 0)
            @(posedge clk);
    endtask

    // mostly table loads and encodes over a small alphabet, some finishes, a bit of noise
    task run_phase(input int unsigned count, input int unsigned tx_pct, input int unsigned rx_pct);
        int unsigned     sent;
        int unsigned     pick;
        int unsigned     len_pick;
        logic [OP_W-1:0] op;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                op = OP_UNUSED;
            else if (pick < 28)
                op = OP_LOAD;
            else if (pick < 90)
                op = OP_ENCODE;
            else
                op = OP_FINISH;
            sym = ($urandom_range(3) == 0) ? SYM_W'($urandom_range(127))
                                           : SYM_W'($urandom_range(15));
            len_pick = $urandom_range(19);
            if (len_pick == 0)
                len = '0;
            else if (len_pick < 16)
                len = LEN_W'($urandom_range(12, 1));
            else
                len = LEN_W'($urandom_range(31, 13));
            send_request(op, sym, CODE_W'($urandom), len);
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_LOAD;
        symbol       = '0;
        code_bits    = '0;
        code_length  = '0;
        out_ready    = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        stall_cycles = 0;
        loads_taken    = 0;
        encodes_taken  = 0;
        finishes_taken = 0;
        others_taken   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unused op, extremes, masking, finish corners
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ENCODE, 7'd5, '0, '0);
        send_request(OP_UNUSED, '1, '1, '1);
        send_request(OP_LOAD, 7'd127, 31'h7fff_ffff, 5'd31);
        send_request(OP_LOAD, 7'd0, 31'h7fff_ffff, 5'd3);
        send_request(OP_LOAD, 7'd1, '0, 5'd1);
        send_request(OP_LOAD, 7'd2, 31'h2a, 5'd6);
        send_request(OP_ENCODE, 7'd1, '0, '0);
        send_request(OP_ENCODE, 7'd2, '0, '0);
        // seven pending bits plus the longest code
        send_request(OP_ENCODE, 7'd127, '0, '0);
        send_request(OP_ENCODE, 7'd1, '0, '0);
        send_request(OP_LOAD, 7'd0, 31'h2aaa_aaaa, 5'd31);
        send_request(OP_FINISH, '0, '0, '0);
        // end marker lands exactly on a byte boundary
        send_request(OP_LOAD, 7'd0, 31'h15, 5'd5);
        send_request(OP_ENCODE, 7'd1, '0, '0);
        send_request(OP_ENCODE, 7'd1, '0, '0);
        send_request(OP_ENCODE, 7'd1, '0, '0);
        send_request(OP_FINISH, '0, '0, '0);
        // finish that only pads
        send_request(OP_LOAD, 7'd0, 31'h5555_5555, 5'd0);
        send_request(OP_ENCODE, 7'd1, '0, '0);
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_LOAD, 7'd3, '0, 5'd8);
        send_request(OP_ENCODE, 7'd3, '0, '0);
        send_request(OP_LOAD, 7'd127, 31'h7fff_ffff, 5'd0);
        send_request(OP_ENCODE, 7'd127, '0, '0);
        wait_drained();

        run_phase(110, 19, 75);
        run_phase(55, 75, 19);
        wait_drained();
        run_phase(55, 75, 19);
        hold_request = 1'b1;
        run_phase(40, 0, 0);
        run_phase(90, 0, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        board.check_leftover();
        $display("covered %0d loads, %0d encodes, %0d finishes, %0d unused-op requests",
                 loads_taken, encodes_taken, finishes_taken, others_taken);
        $display("checked %0d bytes under mixed idling and a %0d-cycle output hold-off",
                 board.bytes_checked, HOLD_CYCLES);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_code_table.sv
hw/rtl/hcbp_packer.sv
hw/rtl/huffman_code_bit_packer_top.sv
sim/tb_huffman_code_bit_packer_top.sv
